>>> rtl/umds_pkg.sv
// Shared types and constants for the USB MIDI endpoint descriptor scan.
package umds_pkg;

   localparam logic [7:0] KIND_INTERFACE = 8'h04;
   localparam logic [7:0] KIND_ENDPOINT  = 8'h05;
   localparam logic [7:0] EP_DIR_IN      = 8'h80;
   localparam logic [7:0] ATTR_BULK      = 8'h02;

   localparam logic [7:0] MATCH_CLASS_RESET    = 8'h01;
   localparam logic [7:0] MATCH_SUBCLASS_RESET = 8'h03;

   localparam logic [15:0] POS_MAX = 16'hFFFF;

   // Configuration register indexes
   localparam logic CSR_MATCH_CLASS    = 1'b0;
   localparam logic CSR_MATCH_SUBCLASS = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       midi_found;
      logic [7:0] in_endpoint;
      logic [7:0] out_endpoint;
      logic [7:0] interface_number;
      logic       format_error;
   } rsp_type;

   typedef struct packed {
      logic [7:0] match_class;
      logic [7:0] match_subclass;
   } cfg_type;

endpackage

>>> rtl/umds_csr.sv
// Configuration registers: interface class and subclass to match.
module umds_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata,
   output umds_pkg::cfg_type cfg
);
   import umds_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_class    <= MATCH_CLASS_RESET;
         cfg_ff.match_subclass <= MATCH_SUBCLASS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MATCH_CLASS:    cfg_ff.match_class    <= csr_wdata;
            CSR_MATCH_SUBCLASS: cfg_ff.match_subclass <= csr_wdata;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/umds_walk.sv
// Descriptor walker: per-byte state update and result capture values.
module umds_walk (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  umds_pkg::req_type item,
   input  umds_pkg::cfg_type cfg,
   output umds_pkg::rsp_type result
);
   import umds_pkg::*;

   logic [15:0] pos_ff, pos_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  off_ff, off_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  kind_ff, kind_in;
   logic        iface_seen_ff, iface_seen_in;
   logic [7:0]  iface_class_ff, iface_class_in;
   logic [7:0]  iface_sub_ff, iface_sub_in;
   logic [7:0]  iface_num_ff, iface_num_in;
   logic [7:0]  ep_addr_ff, ep_addr_in;
   logic        found_ff, found_in;
   logic [7:0]  in_ep_ff, in_ep_in;
   logic [7:0]  out_ep_ff, out_ep_in;
   logic [7:0]  iface_res_ff, iface_res_in;
   logic        error_ff, error_in;

   logic [7:0] b;
   logic       qualifies;
   logic       walk;
   logic       halt;

   always_comb begin
      b = item.data_byte;
      total_in       = total_ff;
      off_in         = off_ff;
      len_in         = len_ff;
      kind_in        = kind_ff;
      iface_seen_in  = iface_seen_ff;
      iface_class_in = iface_class_ff;
      iface_sub_in   = iface_sub_ff;
      iface_num_in   = iface_num_ff;
      ep_addr_in     = ep_addr_ff;
      found_in       = found_ff;
      in_ep_in       = in_ep_ff;
      out_ep_in      = out_ep_ff;
      iface_res_in   = iface_res_ff;
      error_in       = error_ff;
      halt           = 1'b0;

      if (pos_ff == 16'd2) begin
         total_in = {total_ff[15:8], b};
      end else if (pos_ff == 16'd3) begin
         total_in = {b, total_ff[7:0]};
      end

      qualifies = iface_seen_ff && (iface_class_ff == cfg.match_class) &&
                  (iface_sub_ff == cfg.match_subclass);
      walk = !error_ff && ((pos_ff < 16'd4) || (pos_ff < total_in));

      if (walk) begin
         if (off_ff == 8'd0) begin
            if (b == 8'd0) begin
               error_in = 1'b1;
               halt     = 1'b1;
            end else begin
               len_in  = b;
               kind_in = 8'd0;
            end
         end else if (off_ff == 8'd1) begin
            kind_in = b;
            if (b == KIND_INTERFACE) begin
               iface_seen_in  = 1'b1;
               iface_class_in = 8'd0;
               iface_sub_in   = 8'd0;
               iface_num_in   = 8'd0;
            end
         end else if (kind_ff == KIND_INTERFACE) begin
            if (off_ff == 8'd2) begin
               iface_num_in = b;
            end else if (off_ff == 8'd5) begin
               iface_class_in = b;
            end else if (off_ff == 8'd6) begin
               iface_sub_in = b;
            end
         end else if (kind_ff == KIND_ENDPOINT) begin
            if (off_ff == 8'd2) begin
               ep_addr_in = b;
               if (qualifies && ((b & EP_DIR_IN) != 8'd0)) begin
                  in_ep_in     = b;
                  found_in     = 1'b1;
                  iface_res_in = iface_num_ff;
               end
            end else if (off_ff == 8'd3) begin
               if (qualifies && ((ep_addr_ff & EP_DIR_IN) == 8'd0) && (b == ATTR_BULK)) begin
                  out_ep_in = ep_addr_ff;
               end
            end
         end

         // offset wraps against the length as it stands after this byte
         if (!halt) begin
            if (({1'b0, off_ff} + 9'd1) >= {1'b0, len_in}) begin
               off_in = 8'd0;
            end else begin
               off_in = off_ff + 8'd1;
            end
         end
      end

      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 16'd1;

      result.midi_found       = found_in;
      result.in_endpoint      = in_ep_in;
      result.out_endpoint     = out_ep_in;
      result.interface_number = iface_res_in;
      result.format_error     = error_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         pos_ff         <= '0;
         total_ff       <= '0;
         off_ff         <= '0;
         len_ff         <= '0;
         kind_ff        <= '0;
         iface_seen_ff  <= 1'b0;
         iface_class_ff <= '0;
         iface_sub_ff   <= '0;
         iface_num_ff   <= '0;
         ep_addr_ff     <= '0;
         found_ff       <= 1'b0;
         in_ep_ff       <= '0;
         out_ep_ff      <= '0;
         iface_res_ff   <= '0;
         error_ff       <= 1'b0;
      end else if (step) begin
         pos_ff         <= pos_in;
         total_ff       <= total_in;
         off_ff         <= off_in;
         len_ff         <= len_in;
         kind_ff        <= kind_in;
         iface_seen_ff  <= iface_seen_in;
         iface_class_ff <= iface_class_in;
         iface_sub_ff   <= iface_sub_in;
         iface_num_ff   <= iface_num_in;
         ep_addr_ff     <= ep_addr_in;
         found_ff       <= found_in;
         in_ep_ff       <= in_ep_in;
         out_ep_ff      <= out_ep_in;
         iface_res_ff   <= iface_res_in;
         error_ff       <= error_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step && item.last_byte |=> pos_ff == 16'd0 && !error_ff && !found_ff)
      else $error("state not cleared after last item");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_ff && !(step && item.last_byte) |=> error_ff)
      else $error("format error dropped mid-set");

   a_found_has_ep: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> in_ep_ff[7] && iface_seen_ff)
      else $error("found flag without IN endpoint");

endmodule

>>> rtl/umds_obuf.sv
// Two-entry result buffer: output register plus skid entry.
module umds_obuf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  umds_pkg::rsp_type push_data,
   output logic              space,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output umds_pkg::rsp_type rsp_data
);
   import umds_pkg::*;

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    pop;

   assign pop = main_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         main_ff <= skid_valid_ff ? skid_ff : push_data;
      end else if (push) begin
         if (main_valid_ff) begin
            skid_ff <= push_data;
         end else begin
            main_ff <= push_data;
         end
      end
   end

   assign space     = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without output entry");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("item pushed into full result buffer");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push && !main_valid_ff |=> main_valid_ff)
      else $error("pushed item lost");

endmodule

>>> rtl/usb_midi_endpoint_descriptor_scan.sv
// Top level of the USB MIDI endpoint descriptor scan.
//
//   channel   dir   handshake              payload
//   req       in    req_valid/req_ready    req_data  (data_byte, last_byte)
//   rsp       out   rsp_valid/rsp_ready    rsp_data  (found, endpoints, iface, error)
//   csr       in    csr_we                 csr_index, csr_wdata
//
// One byte per cycle sustained, but for the stall below: a byte is held in the input register,
// then updates the walker state; a last byte puts its result into the result buffer
// as it leaves the input register. A two-entry result buffer keeps bytes
// flowing while a result waits; input stalls only when a last byte waits in the
// input register while both entries are full.
// Synchronous reset clears the valid flags and walker state and restores match class 1, subclass 3.
module usb_midi_endpoint_descriptor_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  umds_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output umds_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);
   import umds_pkg::*;

   logic    in_valid_ff;
   req_type in_ff;
   logic    advance;
   logic    space;
   cfg_type cfg;
   rsp_type result;

   // a last byte may only move on when the result buffer has room
   assign advance   = in_valid_ff && (!in_ff.last_byte || space);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
   end

   umds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   umds_walk u_walk (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_ff),
      .cfg    (cfg),
      .result (result)
   );

   umds_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && in_ff.last_byte),
      .push_data (result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/sv/umds_scan_checker.sv
// Checker for the descriptor scan: mirrors the walk, queues expected summaries, compares results.
module umds_scan_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  umds_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  umds_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata,
   output int unsigned       fail_count,
   output int unsigned       pending,
   output int unsigned       results_checked
);
   import umds_pkg::*;

   localparam logic [7:0] OFS_LENGTH      = 8'd0;
   localparam logic [7:0] OFS_KIND        = 8'd1;
   localparam logic [7:0] OFS_IF_NUMBER   = 8'd2;
   localparam logic [7:0] OFS_IF_CLASS    = 8'd5;
   localparam logic [7:0] OFS_IF_SUBCLASS = 8'd6;
   localparam logic [7:0] OFS_EP_ADDRESS  = 8'd2;
   localparam logic [7:0] OFS_EP_ATTR     = 8'd3;

   localparam logic [15:0] POS_TOTAL_LO = 16'd2;
   localparam logic [15:0] POS_TOTAL_HI = 16'd3;
   localparam logic [15:0] HEADER_BYTES = 16'd4;

   logic [7:0]  cfg_class;
   logic [7:0]  cfg_subclass;

   logic [15:0] byte_pos;
   logic [15:0] total_len;
   logic [7:0]  desc_offset;
   logic [7:0]  desc_length;
   logic [7:0]  desc_kind;
   logic        iface_seen;
   logic [7:0]  iface_class;
   logic [7:0]  iface_subclass;
   logic [7:0]  iface_number;
   logic [7:0]  ep_address;
   logic        found;
   logic [7:0]  in_ep;
   logic [7:0]  out_ep;
   logic [7:0]  owner_iface;
   logic        length_error;

   rsp_type expected_summaries[$];

   task automatic clear_walk();
      byte_pos       = '0;
      total_len      = '0;
      desc_offset    = '0;
      desc_length    = '0;
      desc_kind      = '0;
      iface_seen     = 1'b0;
      iface_class    = '0;
      iface_subclass = '0;
      iface_number   = '0;
      ep_address     = '0;
      found          = 1'b0;
      in_ep          = '0;
      out_ep         = '0;
      owner_iface    = '0;
      length_error   = 1'b0;
   endtask

   task automatic walk_descriptor_byte(input logic [7:0] b);
      logic qualifies;
      qualifies = iface_seen && iface_class == cfg_class && iface_subclass == cfg_subclass;
      if (desc_offset == OFS_LENGTH && b == 8'h00) begin
         // zero length would never advance: flag it and stop walking
         length_error = 1'b1;
      end else begin
         if (desc_offset == OFS_LENGTH) begin
            desc_length = b;
            desc_kind   = 8'h00;
         end else if (desc_offset == OFS_KIND) begin
            desc_kind = b;
            if (b == KIND_INTERFACE) begin
               iface_seen     = 1'b1;
               iface_class    = 8'h00;
               iface_subclass = 8'h00;
               iface_number   = 8'h00;
            end
         end else if (desc_kind == KIND_INTERFACE) begin
            if (desc_offset == OFS_IF_NUMBER)
               iface_number = b;
            else if (desc_offset == OFS_IF_CLASS)
               iface_class = b;
            else if (desc_offset == OFS_IF_SUBCLASS)
               iface_subclass = b;
         end else if (desc_kind == KIND_ENDPOINT) begin
            if (desc_offset == OFS_EP_ADDRESS) begin
               ep_address = b;
               if (qualifies && (b & EP_DIR_IN) != 8'h00) begin
                  in_ep       = b;
                  found       = 1'b1;
                  owner_iface = iface_number;
               end
            end else if (desc_offset == OFS_EP_ATTR) begin
               if (qualifies && (ep_address & EP_DIR_IN) == 8'h00 && b == ATTR_BULK)
                  out_ep = ep_address;
            end
         end
         if ({1'b0, desc_offset} + 9'd1 >= {1'b0, desc_length})
            desc_offset = 8'h00;
         else
            desc_offset = desc_offset + 8'd1;
      end
   endtask

   task automatic scan_step(input req_type item);
      logic [15:0] pos;
      rsp_type     summary;
      pos = byte_pos;
      if (pos == POS_TOTAL_LO)
         total_len[7:0] = item.data_byte;
      else if (pos == POS_TOTAL_HI)
         total_len[15:8] = item.data_byte;
      if (!length_error && (pos < HEADER_BYTES || pos < total_len))
         walk_descriptor_byte(item.data_byte);
      if (byte_pos != POS_MAX)
         byte_pos = byte_pos + 16'd1;
      if (item.last_byte) begin
         summary.midi_found       = found;
         summary.in_endpoint      = in_ep;
         summary.out_endpoint     = out_ep;
         summary.interface_number = owner_iface;
         summary.format_error     = length_error;
         expected_summaries.push_back(summary);
         clear_walk();
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         cfg_class    = MATCH_CLASS_RESET;
         cfg_subclass = MATCH_SUBCLASS_RESET;
         clear_walk();
         expected_summaries.delete();
      end else begin
         // compare before queueing: a summary never leaves in the cycle its last byte enters
         if (rsp_valid && rsp_ready) begin
            if (expected_summaries.size() == 0) begin
               $error("unexpected result: found=%0b in=0x%02h out=0x%02h if=0x%02h err=%0b",
                      rsp_data.midi_found, rsp_data.in_endpoint, rsp_data.out_endpoint,
                      rsp_data.interface_number, rsp_data.format_error);
               fail_count++;
            end else begin
               want = expected_summaries.pop_front();
               check_field("midi_found", {7'b0, want.midi_found}, {7'b0, rsp_data.midi_found});
               check_field("in_endpoint", want.in_endpoint, rsp_data.in_endpoint);
               check_field("out_endpoint", want.out_endpoint, rsp_data.out_endpoint);
               check_field("interface_number", want.interface_number, rsp_data.interface_number);
               check_field("format_error", {7'b0, want.format_error}, {7'b0, rsp_data.format_error});
               results_checked++;
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_MATCH_CLASS:    cfg_class = csr_wdata;
               CSR_MATCH_SUBCLASS: cfg_subclass = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            scan_step(req_data);
      end
      pending = expected_summaries.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the descriptor scan: clock, reset, descriptor-set stimulus and verdict.
module tb_top;
   import umds_pkg::*;

   localparam logic [7:0] KIND_CONFIG       = 8'h02;
   localparam logic [7:0] KIND_CS_INTERFACE = 8'h24;
   localparam int unsigned PHASES           = 6;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic        csr_index;
   logic [7:0]  csr_wdata;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned results_checked;

   logic [7:0]  desc_bytes[$];
   logic [7:0]  cur_class;
   logic [7:0]  cur_subclass;
   bit          calm;
   int unsigned bytes_sent;
   int unsigned sets_sent;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   usb_midi_endpoint_descriptor_scan u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   umds_scan_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked)
   );

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   function automatic int unsigned idle_cycles(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 13);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic push_byte(input logic [7:0] b, input logic lst);
      int unsigned gap;
      gap = idle_cycles(calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= {b, lst};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_set();
      for (int i = 0; i < desc_bytes.size(); i++)
         push_byte(desc_bytes[i], i == desc_bytes.size() - 1);
      sets_sent++;
   endtask

   // one descriptor: length, kind, then fields from offset 2, random past offset 6
   task automatic put_desc(input int unsigned len, input logic [7:0] kind,
                           input logic [7:0] f2, input logic [7:0] f3, input logic [7:0] f4,
                           input logic [7:0] f5, input logic [7:0] f6);
      logic [7:0] head[7];
      head = '{len[7:0], kind, f2, f3, f4, f5, f6};
      if (len == 0)
         desc_bytes.push_back(8'h00);
      for (int i = 0; i < len; i++)
         desc_bytes.push_back(i < 7 ? head[i] : rand_byte());
   endtask

   task automatic build_random_set();
      int unsigned n_if;
      int unsigned n_ep;
      int unsigned len;
      int unsigned cut;
      logic [31:0] total;
      logic [7:0]  cls;
      logic [7:0]  sub;
      logic [7:0]  addr;
      logic [7:0]  attr;
      desc_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         // plain noise
         repeat ($urandom_range(1, 20)) desc_bytes.push_back(rand_byte());
      end else begin
         put_desc(9, KIND_CONFIG, 8'h00, 8'h00, rand_byte(), rand_byte(), 8'h00);
         if ($urandom_range(0, 5) == 0)
            put_desc(7, KIND_ENDPOINT, rand_byte(), ATTR_BULK, rand_byte(), 8'h00, 8'h01);
         n_if = $urandom_range(0, 3);
         repeat (n_if) begin
            case ($urandom_range(0, 5))
               0: begin cls = rand_byte(); sub = rand_byte(); end
               1: begin cls = cur_class; sub = rand_byte(); end
               2: begin cls = rand_byte(); sub = cur_subclass; end
               default: begin cls = cur_class; sub = cur_subclass; end
            endcase
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 8) : 9;
            put_desc(len, KIND_INTERFACE, rand_byte(), rand_byte(), rand_byte(), cls, sub);
            if ($urandom_range(0, 2) == 0)
               put_desc($urandom_range(1, 12), KIND_CS_INTERFACE, rand_byte(), rand_byte(),
                        rand_byte(), rand_byte(), rand_byte());
            n_ep = $urandom_range(0, 3);
            repeat (n_ep) begin
               addr = rand_byte();
               if ($urandom_range(0, 1) == 1)
                  addr[6:4] = 3'b000;
               attr = ($urandom_range(0, 2) != 0) ? ATTR_BULK : rand_byte();
               case ($urandom_range(0, 5))
                  0: len = $urandom_range(2, 6);
                  1: len = 9;
                  default: len = 7;
               endcase
               put_desc(len, KIND_ENDPOINT, addr, attr, rand_byte(), rand_byte(), rand_byte());
            end
         end
         if ($urandom_range(0, 14) == 0) begin
            desc_bytes.push_back(8'h00);
            repeat ($urandom_range(0, 6)) desc_bytes.push_back(rand_byte());
         end
         total = desc_bytes.size();
         case ($urandom_range(0, 9))
            0: total = $urandom_range(0, total);
            1: total = total + $urandom_range(1, 40);
            2: total = $urandom_range(0, 3);
            3: total = $urandom_range(0, 16'hFFFF);
            default: ;
         endcase
         desc_bytes[2] = total[7:0];
         desc_bytes[3] = total[15:8];
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6)) desc_bytes.push_back(rand_byte());
      end
      // last marked early now and then
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, desc_bytes.size());
         while (desc_bytes.size() > cut) void'(desc_bytes.pop_back());
      end
   endtask

   initial begin : result_sink
      int unsigned gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         gap = idle_cycles($urandom_range(0, 3) == 0);
         if (gap == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            // hold off once a result is waiting so the stall really bites
            rsp_ready <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
            repeat (gap) @(negedge clock);
            rsp_ready <= 1'b1;
         end
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int unsigned start_bytes;
      int unsigned start_sets;
      logic [7:0]  cls;
      logic [7:0]  sub;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_index    = CSR_MATCH_CLASS;
      csr_wdata    = 8'h00;
      cur_class    = MATCH_CLASS_RESET;
      cur_subclass = MATCH_SUBCLASS_RESET;
      calm         = 1'b0;
      bytes_sent   = 0;
      sets_sent    = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            wait (pending == 0);
            repeat (4) @(negedge clock);
            case (phase)
               1: begin cls = 8'h00; sub = 8'h00; end
               2: begin cls = 8'hFF; sub = 8'hFF; end
               4: begin cls = 8'h00; sub = 8'hFF; end
               5: begin cls = MATCH_CLASS_RESET; sub = MATCH_SUBCLASS_RESET; end
               default: begin cls = rand_byte(); sub = rand_byte(); end
            endcase
            csr_we    <= 1'b1;
            csr_index <= CSR_MATCH_CLASS;
            csr_wdata <= cls;
            @(negedge clock);
            csr_index <= CSR_MATCH_SUBCLASS;
            csr_wdata <= sub;
            @(negedge clock);
            csr_we    <= 1'b0;
            cur_class    = cls;
            cur_subclass = sub;
         end

         if (phase == 0) begin
            // matching IN and bulk OUT endpoints with extreme values
            desc_bytes.delete();
            put_desc(4, KIND_CONFIG, 8'd19, 8'h00, 8'h00, 8'h00, 8'h00);
            put_desc(7, KIND_INTERFACE, 8'hFF, 8'h00, 8'h00, MATCH_CLASS_RESET,
                     MATCH_SUBCLASS_RESET);
            put_desc(4, KIND_ENDPOINT, 8'hFF, ATTR_BULK, 8'h00, 8'h00, 8'h00);
            put_desc(4, KIND_ENDPOINT, 8'h7F, ATTR_BULK, 8'h00, 8'h00, 8'h00);
            send_set();
            // short header: the total high byte lands as a zero length
            desc_bytes.delete();
            put_desc(3, KIND_CONFIG, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00);
            desc_bytes.push_back(8'h00);
            send_set();
            // endpoint ahead of any interface
            desc_bytes.delete();
            put_desc(4, KIND_CONFIG, 8'd8, 8'h00, 8'h00, 8'h00, 8'h00);
            put_desc(4, KIND_ENDPOINT, 8'h81, ATTR_BULK, 8'h00, 8'h00, 8'h00);
            send_set();
            // a lone zero byte
            desc_bytes.delete();
            desc_bytes.push_back(8'h00);
            send_set();
         end

         start_bytes = bytes_sent;
         start_sets  = sets_sent;
         while (bytes_sent - start_bytes < 180 || sets_sent - start_sets < 4) begin
            calm = ($urandom_range(0, 4) == 0);
            build_random_set();
            send_set();
         end
         calm = 1'b0;
         req_valid <= 1'b0;
      end

      wait (pending == 0);
      repeat (10) @(posedge clock);
      $display("Checked %0d scan summaries from %0d bytes in %0d sets over %0d match settings,",
               results_checked, bytes_sent, sets_sent, PHASES);
      $display("with short, truncated, zero-length and overstated-total sets under random stalls.");
      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
